// ===== rtl/rrss_pkg.sv =====
package rrss_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PROD_W = 56;
    localparam int unsigned OP_A_W = 32;
    localparam int unsigned OP_B_W = 24;
    localparam int unsigned ACC_W = 38;

    localparam int signed ONE_Q14 = 16384;
    localparam int signed TWO_OVER_PI_Q14 = 10430;
    localparam int signed NEWTON_THREE = 3;
    localparam int unsigned STEP_COS_RST = 16384;
    localparam int unsigned INV_SPAN_RST = 256;

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_COS      = 3'd0,
        REG_STEP_SIN      = 3'd1,
        REG_HARMONIC_MIX  = 3'd2,
        REG_SAG_START     = 3'd3,
        REG_SAG_INV_SPAN  = 3'd4,
        REG_GAIN_SAG      = 3'd5,
        REG_RIPPLE_COEFFS = 3'd6,
        REG_GAIN_LIMITS   = 3'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADV_CSC,
        S_ADV_SSS,
        S_ADV_SSC,
        S_ADV_CSS,
        S_ADV_NC2,
        S_ADV_NS2,
        S_ADV_G,
        S_ADV_CG,
        S_ADV_SG,
        S_ADV_SW,
        S_SC,
        S_MIX,
        S_WAVE,
        S_LOAD,
        S_GT,
        S_KLT,
        S_KSUM,
        S_RG,
        S_RGR,
        S_WRG,
        S_FAC,
        S_BF,
        S_OUT
    } t_state;

    // floor((v + 2^(sh-1)) / 2^sh)
    function automatic t_prod rshr(input t_prod v, input logic [5:0] sh);
        t_prod half;
        half = t_prod'(1) <<< (sh - 6'd1);
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [15:0] sat16(input t_prod v);
        if (v > t_prod'(32767)) begin
            return 16'sh7fff;
        end else if (v < t_prod'(-32768)) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

// ===== rtl/rrss_if.sv =====
interface rrss_in_if;
    logic                               valid;
    logic                               ready;
    logic                               restart;
    logic                               advance;
    logic [rrss_pkg::SAMPLE_W-1:0]      sag_env;
    logic [rrss_pkg::SAMPLE_W-1:0]      branch_depth;

    modport source (output valid, output restart, output advance, output sag_env,
                    output branch_depth, input ready);
    modport sink (input valid, input restart, input advance, input sag_env,
                  input branch_depth, output ready);
endinterface

interface rrss_out_if;
    logic                               valid;
    logic                               ready;
    logic [rrss_pkg::SAMPLE_W-1:0]      supply_scale;
    logic signed [rrss_pkg::SAMPLE_W-1:0] ripple_wave;

    modport source (output valid, output supply_scale, output ripple_wave, input ready);
    modport sink (input valid, input supply_scale, input ripple_wave, output ready);
endinterface

interface rrss_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rrss_pkg::CFG_IDX_W-1:0]     index;
    logic [rrss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rectifier_ripple_supply_scale_unit.sv =====
// Rectifier ripple supply scale. Per sample: optional oscillator restart, optional
// rotation with a one-step Newton renormalization, then ripple wave, load fraction and
// the clamped Q2.14 supply scale. All products go through one registered 32x24 signed
// multiplier stepped by a sequencer, so one sample is in flight at a time. The oscillator
// advances only when advance is set and step_sin is nonzero. The result sits in an
// output register; the next sample is accepted while it waits, and the sequencer stalls
// in its last step only if that register is still full. Configuration writes are always
// accepted and must come while idle.
module rectifier_ripple_supply_scale_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrss_cfg_if.sink    i_cfg,
    rrss_in_if.sink     i_in,
    rrss_out_if.source  o_out
);

    rrss_pkg::t_state r_state;
    rrss_pkg::t_state n_state;

    // configuration
    logic signed [15:0] r_step_cos;
    logic signed [15:0] r_step_sin;
    logic signed [15:0] r_mix;
    logic [15:0]        r_sag_start;
    logic [15:0]        r_inv_span;
    logic [15:0]        r_gsag;
    logic [31:0]        r_coeffs;
    logic [31:0]        r_limits;

    // oscillator
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;

    // working registers
    logic [15:0]                        r_env;
    logic [15:0]                        r_branch;
    rrss_pkg::t_prod                    r_prod;
    logic signed [rrss_pkg::ACC_W-1:0]  r_acc;
    logic signed [18:0]                 r_nc;
    logic signed [18:0]                 r_ns;
    logic signed [21:0]                 r_g;
    logic signed [15:0]                 r_wave;
    logic [14:0]                        r_t;
    logic signed [17:0]                 r_base;

    // output register
    logic               r_ovalid;
    logic [15:0]        r_out_scale;
    logic signed [15:0] r_out_wave;

    logic                                w_mul_en;
    logic signed [rrss_pkg::OP_A_W-1:0]  w_op_a;
    logic signed [rrss_pkg::OP_B_W-1:0]  w_op_b;
    logic                                w_in_acc;
    logic                                w_out_load;

    rrss_pkg::t_prod    w_r14;
    rrss_pkg::t_prod    w_r8;
    rrss_pkg::t_prod    w_r27;
    rrss_pkg::t_prod    w_sum;
    rrss_pkg::t_prod    w_wave_sum;
    rrss_pkg::t_prod    w_g_arg;
    logic [16:0]        w_abs_s;
    logic [16:0]        w_d;
    logic               w_d_pos;
    logic [14:0]        w_t;
    logic [15:0]        w_lo;
    logic [15:0]        w_hi;
    rrss_pkg::t_prod    w_clamp;
    logic [15:0]        w_scale;

    assign i_cfg.ready      = 1'b1;
    assign i_in.ready       = (r_state == rrss_pkg::S_IDLE);
    assign w_in_acc         = i_in.valid && (r_state == rrss_pkg::S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.supply_scale = r_out_scale;
    assign o_out.ripple_wave  = r_out_wave;

    // rounded views of the last product
    assign w_r14 = rrss_pkg::rshr(r_prod, 6'd14);
    assign w_r8  = rrss_pkg::rshr(r_prod, 6'd8);
    assign w_r27 = rrss_pkg::rshr(r_prod, 6'd27);
    assign w_sum = rrss_pkg::t_prod'(r_acc) + r_prod;
    assign w_g_arg = (rrss_pkg::t_prod'(rrss_pkg::NEWTON_THREE) <<< 28) - w_sum;

    assign w_abs_s = r_sin[15] ? (17'd0 - {r_sin[15], r_sin}) : {1'b0, r_sin};
    assign w_wave_sum = rrss_pkg::t_prod'(w_abs_s)
                      - rrss_pkg::t_prod'(rrss_pkg::TWO_OVER_PI_Q14) + w_r27;

    assign w_d     = {1'b0, r_env} - {1'b0, r_sag_start};
    assign w_d_pos = !w_d[16] && (w_d != 17'd0);

    always_comb begin
        if (!w_d_pos || (r_inv_span == 16'd0)) begin
            w_t = 15'd0;
        end else if (w_r8 > rrss_pkg::t_prod'(rrss_pkg::ONE_Q14)) begin
            w_t = 15'(rrss_pkg::ONE_Q14);
        end else begin
            w_t = w_r8[14:0];
        end
    end

    assign w_lo = (r_limits[15:0] < r_limits[31:16]) ? r_limits[15:0] : r_limits[31:16];
    assign w_hi = (r_limits[15:0] < r_limits[31:16]) ? r_limits[31:16] : r_limits[15:0];

    always_comb begin
        w_clamp = w_r14;
        if (w_hi != 16'd0) begin
            if (w_clamp < rrss_pkg::t_prod'(w_lo)) begin
                w_clamp = rrss_pkg::t_prod'(w_lo);
            end
            if (w_clamp > rrss_pkg::t_prod'(w_hi)) begin
                w_clamp = rrss_pkg::t_prod'(w_hi);
            end
        end
        if (w_clamp < rrss_pkg::t_prod'(0)) begin
            w_scale = 16'd0;
        end else if (w_clamp > rrss_pkg::t_prod'(65535)) begin
            w_scale = 16'hffff;
        end else begin
            w_scale = w_clamp[15:0];
        end
    end

    assign w_out_load = (r_state == rrss_pkg::S_OUT) && (!r_ovalid || o_out.ready);

    // sequencer: next state and multiplier operands
    always_comb begin
        n_state  = r_state;
        w_mul_en = 1'b0;
        w_op_a   = '0;
        w_op_b   = '0;
        case (r_state)
            rrss_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.advance && (r_step_sin != 16'sd0)) begin
                        n_state = rrss_pkg::S_ADV_CSC;
                    end else begin
                        n_state = rrss_pkg::S_SC;
                    end
                end
            end
            rrss_pkg::S_ADV_CSC: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_cos);
                w_op_b   = 24'(r_step_cos);
                n_state  = rrss_pkg::S_ADV_SSS;
            end
            rrss_pkg::S_ADV_SSS: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_sin);
                w_op_b   = 24'(r_step_sin);
                n_state  = rrss_pkg::S_ADV_SSC;
            end
            rrss_pkg::S_ADV_SSC: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_sin);
                w_op_b   = 24'(r_step_cos);
                n_state  = rrss_pkg::S_ADV_CSS;
            end
            rrss_pkg::S_ADV_CSS: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_cos);
                w_op_b   = 24'(r_step_sin);
                n_state  = rrss_pkg::S_ADV_NC2;
            end
            rrss_pkg::S_ADV_NC2: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_nc);
                w_op_b   = 24'(r_nc);
                n_state  = rrss_pkg::S_ADV_NS2;
            end
            rrss_pkg::S_ADV_NS2: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_ns);
                w_op_b   = 24'(r_ns);
                n_state  = rrss_pkg::S_ADV_G;
            end
            rrss_pkg::S_ADV_G: begin
                n_state = rrss_pkg::S_ADV_CG;
            end
            rrss_pkg::S_ADV_CG: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_nc);
                w_op_b   = 24'(r_g);
                n_state  = rrss_pkg::S_ADV_SG;
            end
            rrss_pkg::S_ADV_SG: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_ns);
                w_op_b   = 24'(r_g);
                n_state  = rrss_pkg::S_ADV_SW;
            end
            rrss_pkg::S_ADV_SW: begin
                n_state = rrss_pkg::S_SC;
            end
            rrss_pkg::S_SC: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_cos);
                w_op_b   = 24'(r_sin);
                n_state  = rrss_pkg::S_MIX;
            end
            rrss_pkg::S_MIX: begin
                w_mul_en = 1'b1;
                w_op_a   = r_prod[31:0];
                w_op_b   = 24'(r_mix);
                n_state  = rrss_pkg::S_WAVE;
            end
            rrss_pkg::S_WAVE: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(w_d[15:0]);
                w_op_b   = 24'(r_inv_span);
                n_state  = rrss_pkg::S_LOAD;
            end
            rrss_pkg::S_LOAD: begin
                n_state = rrss_pkg::S_GT;
            end
            rrss_pkg::S_GT: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_t);
                w_op_b   = 24'(r_gsag);
                n_state  = rrss_pkg::S_KLT;
            end
            rrss_pkg::S_KLT: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_t);
                w_op_b   = 24'(r_coeffs[31:16]);
                n_state  = rrss_pkg::S_KSUM;
            end
            rrss_pkg::S_KSUM: begin
                n_state = rrss_pkg::S_RG;
            end
            rrss_pkg::S_RG: begin
                w_mul_en = 1'b1;
                w_op_a   = r_acc[31:0];
                w_op_b   = 24'(r_branch);
                n_state  = rrss_pkg::S_RGR;
            end
            rrss_pkg::S_RGR: begin
                n_state = rrss_pkg::S_WRG;
            end
            rrss_pkg::S_WRG: begin
                w_mul_en = 1'b1;
                w_op_a   = r_acc[31:0];
                w_op_b   = 24'(r_wave);
                n_state  = rrss_pkg::S_FAC;
            end
            rrss_pkg::S_FAC: begin
                n_state = rrss_pkg::S_BF;
            end
            rrss_pkg::S_BF: begin
                w_mul_en = 1'b1;
                w_op_a   = 32'(r_base);
                w_op_b   = r_acc[23:0];
                n_state  = rrss_pkg::S_OUT;
            end
            rrss_pkg::S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || o_out.ready) begin
                    n_state = rrss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, oscillator and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cos  <= 16'(rrss_pkg::STEP_COS_RST);
            r_step_sin  <= '0;
            r_mix       <= '0;
            r_sag_start <= '0;
            r_inv_span  <= 16'(rrss_pkg::INV_SPAN_RST);
            r_gsag      <= '0;
            r_coeffs    <= '0;
            r_limits    <= '0;
            r_cos       <= 16'(rrss_pkg::ONE_Q14);
            r_sin       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (rrss_pkg::t_reg_idx'(i_cfg.index))
                    rrss_pkg::REG_STEP_COS:      r_step_cos  <= i_cfg.data[15:0];
                    rrss_pkg::REG_STEP_SIN:      r_step_sin  <= i_cfg.data[15:0];
                    rrss_pkg::REG_HARMONIC_MIX:  r_mix       <= i_cfg.data[15:0];
                    rrss_pkg::REG_SAG_START:     r_sag_start <= i_cfg.data[15:0];
                    rrss_pkg::REG_SAG_INV_SPAN:  r_inv_span  <= i_cfg.data[15:0];
                    rrss_pkg::REG_GAIN_SAG:      r_gsag      <= i_cfg.data[15:0];
                    rrss_pkg::REG_RIPPLE_COEFFS: r_coeffs    <= i_cfg.data;
                    rrss_pkg::REG_GAIN_LIMITS:   r_limits    <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_in_acc && i_in.restart) begin
                r_cos <= 16'(rrss_pkg::ONE_Q14);
                r_sin <= '0;
            end
            if (r_state == rrss_pkg::S_ADV_SG) begin
                r_cos <= rrss_pkg::sat16(w_r14);
            end
            if (r_state == rrss_pkg::S_ADV_SW) begin
                r_sin <= rrss_pkg::sat16(w_r14);
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= rrss_pkg::t_prod'(w_op_a) * rrss_pkg::t_prod'(w_op_b);
        end
        if (w_in_acc) begin
            r_env    <= i_in.sag_env;
            r_branch <= i_in.branch_depth;
        end
        if (w_out_load) begin
            r_out_scale <= w_scale;
            r_out_wave  <= r_wave;
        end
        case (r_state)
            rrss_pkg::S_ADV_SSS: r_acc  <= rrss_pkg::ACC_W'(r_prod);
            rrss_pkg::S_ADV_SSC: begin
                r_nc <= 19'(rrss_pkg::rshr(rrss_pkg::t_prod'(r_acc) - r_prod, 6'd14));
            end
            rrss_pkg::S_ADV_CSS: r_acc  <= rrss_pkg::ACC_W'(r_prod);
            rrss_pkg::S_ADV_NC2: r_ns   <= 19'(rrss_pkg::rshr(w_sum, 6'd14));
            rrss_pkg::S_ADV_NS2: r_acc  <= rrss_pkg::ACC_W'(r_prod);
            rrss_pkg::S_ADV_G:   r_g    <= 22'(rrss_pkg::rshr(w_g_arg, 6'd15));
            rrss_pkg::S_WAVE:    r_wave <= rrss_pkg::sat16(w_wave_sum);
            rrss_pkg::S_LOAD:    r_t    <= w_t;
            rrss_pkg::S_KLT: begin
                r_base <= 18'(rrss_pkg::t_prod'(rrss_pkg::ONE_Q14) - w_r14);
            end
            rrss_pkg::S_KSUM: begin
                r_acc <= rrss_pkg::ACC_W'(rrss_pkg::t_prod'(r_coeffs[15:0]) + w_r14);
            end
            rrss_pkg::S_RGR:     r_acc  <= rrss_pkg::ACC_W'(w_r14);
            rrss_pkg::S_FAC: begin
                r_acc <= rrss_pkg::ACC_W'(rrss_pkg::t_prod'(rrss_pkg::ONE_Q14) + w_r14);
            end
            default: ;
        endcase
    end

endmodule
